>>> rtl/dqs_pkg.sv
`timescale 1ns / 1ps

package dqs_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_INDEX = 2'd3
   } status_type;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned COUNT_W = 9;

endpackage

>>> rtl/dqs_store.sv
`timescale 1ns / 1ps

module dqs_store
   import dqs_pkg::*;
#(
   parameter int unsigned CAPACITY = 256,
   parameter int unsigned ADDR_W   = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [CAPACITY];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dqs_control.sv
`timescale 1ns / 1ps

module dqs_control
   import dqs_pkg::*;
#(
   parameter int unsigned CAPACITY = 256,
   parameter int unsigned ADDR_W   = 8,
   parameter int unsigned CNT_W    = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic [WORD_W-1:0]  req_value,
   input  logic [INDEX_W-1:0] req_index,
   output logic               wr_en,
   output logic [ADDR_W-1:0]  wr_addr,
   output logic [WORD_W-1:0]  wr_data,
   output logic [ADDR_W-1:0]  rd_addr,
   input  logic [WORD_W-1:0]  rd_data,
   output logic               rsp_strobe,
   output logic [WORD_W-1:0]  rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [COUNT_W-1:0] rsp_count
);

   localparam int unsigned XW = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [ADDR_W:0]   CAP_SUM  = (ADDR_W + 1)'(CAPACITY);
   localparam logic [ADDR_W-1:0] LAST     = ADDR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);

   logic [ADDR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              busy_ff;
   logic              rsp_strobe_ff;
   logic              rd_ok_ff, rd_ok_in;
   status_type        status_ff, status_in;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic              accept;
   logic              full, empty;
   logic [XW-1:0]     index_x, count_x;
   logic [ADDR_W-1:0] logical;
   logic [ADDR_W:0]   slot_sum;
   logic [ADDR_W-1:0] slot;
   logic [ADDR_W-1:0] front_dec, front_inc;

   assign accept  = start && !busy_ff;
   assign full    = (count_ff == CAP_CNT);
   assign empty   = (count_ff == '0);
   assign index_x = XW'(req_index);
   assign count_x = XW'(count_ff);

   assign front_dec = (front_ff == '0) ? LAST : front_ff - ADDR_W'(1);
   assign front_inc = (front_ff == LAST) ? '0 : front_ff + ADDR_W'(1);

   always_comb begin
      if (req_op == OP_READ) begin
         logical = index_x[ADDR_W-1:0];
      end else begin
         logical = count_ff[ADDR_W-1:0];
      end
      slot_sum = {1'b0, front_ff} + {1'b0, logical};
      if (slot_sum >= CAP_SUM) begin
         slot_sum = slot_sum - CAP_SUM;
      end
      slot = slot_sum[ADDR_W-1:0];
   end

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = slot;
      case (req_op)
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_PUSH_FRONT: begin
            wr_addr = front_dec;
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = accept;
               front_in = front_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               front_in = front_inc;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (index_x >= count_x) begin
               status_in = ST_INDEX;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_data = req_value;
   assign rd_addr = slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= accept;
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ok_ff     <= rd_ok_in;
         status_ff    <= status_in;
         rsp_count_ff <= COUNT_W'(count_in);
      end
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rd_ok_ff ? rd_data : '0;
   assign rsp_status     = status_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

>>> rtl/double_ended_queue_store.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of 64-bit words kept in a ring memory.
// A request is taken at a rising edge where start is high and busy is low.
// req_op selects push back, pop back, push front, pop front or read; req_value
// is the word to push and req_index the position to read, counted from the front.
// Every request yields exactly one response, shown for one cycle with
// rsp_strobe high in the cycle after the request is taken: the word read
// (zero unless a good read), a status code and the element count afterwards.
// The receiver cannot stall, so the response is dropped if not sampled.
// Throughput is one request per cycle while busy is low; the word read comes
// from the registered read port of the element memory.
// A push when full is refused, a pop when empty is ignored, and a read at or
// beyond the count is flagged, each leaving the contents unchanged.
// Synchronous reset empties the queue and holds busy high while reset is
// asserted and until the first rising edge that samples it low; the memory
// contents are not cleared and are only ever read once written.

module double_ended_queue_store
   import dqs_pkg::*;
#(
   parameter int unsigned CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic [WORD_W-1:0]  req_value,
   input  logic [INDEX_W-1:0] req_index,
   output logic               rsp_strobe,
   output logic [WORD_W-1:0]  rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [COUNT_W-1:0] rsp_count
);

   localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   dqs_store #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dqs_control #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W),
      .CNT_W    (CNT_W)
   ) u_control (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_value      (req_value),
      .req_index      (req_index),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import dqs_pkg::*;

   localparam int unsigned DEPTH = 256;
   localparam int unsigned RANDOM_REQUESTS = 900;
   localparam int unsigned CYCLE_LIMIT = 200000;

   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
   } reply_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [WORD_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      logic               typed;
      reply_type          reply;
   } stim_row_type;

   localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
   localparam logic [WORD_W-1:0] ZERO = {WORD_W{1'b0}};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_op = OP_PUSH_BACK;
   logic [WORD_W-1:0]  req_value = '0;
   logic [INDEX_W-1:0] req_index = '0;
   logic               rsp_strobe;
   logic [WORD_W-1:0]  rsp_read_value;
   logic [1:0]         rsp_status;
   logic [COUNT_W-1:0] rsp_count;

   logic [WORD_W-1:0]  ring_words [DEPTH];
   logic [INDEX_W-1:0] ring_head = '0;
   logic [COUNT_W-1:0] held_count = '0;

   reply_type   expected_ring [16];
   int unsigned queued_total = 0;
   int unsigned checked_total = 0;
   int unsigned failures = 0;
   int unsigned cycles = 0;
   bit          bursty = 1'b0;

   stim_row_type directed_rows [0:23] = '{
      '{OP_POP_BACK,   ZERO, 8'd0,   1'b1, '{ZERO, ST_EMPTY, 9'd0}},
      '{OP_POP_FRONT,  ZERO, 8'd0,   1'b1, '{ZERO, ST_EMPTY, 9'd0}},
      '{OP_READ,       ZERO, 8'd0,   1'b1, '{ZERO, ST_INDEX, 9'd0}},
      '{OP_READ,       ONES, 8'd255, 1'b1, '{ZERO, ST_INDEX, 9'd0}},
      '{OP_PUSH_BACK,  ONES, 8'd0,   1'b1, '{ZERO, ST_OK,    9'd1}},
      '{OP_READ,       ZERO, 8'd0,   1'b1, '{ONES, ST_OK,    9'd1}},
      '{OP_PUSH_FRONT, ZERO, 8'd255, 1'b1, '{ZERO, ST_OK,    9'd2}},
      '{OP_READ,       ONES, 8'd0,   1'b1, '{ZERO, ST_OK,    9'd2}},
      '{OP_READ,       ZERO, 8'd1,   1'b1, '{ONES, ST_OK,    9'd2}},
      '{OP_READ,       ZERO, 8'd2,   1'b1, '{ZERO, ST_INDEX, 9'd2}},
      '{OP_SPARE_LO,   ONES, 8'd255, 1'b1, '{ZERO, ST_OK,    9'd2}},
      '{OP_SPARE_MID,  ONES, 8'd0,   1'b1, '{ZERO, ST_OK,    9'd2}},
      '{OP_SPARE_HI,   ZERO, 8'd255, 1'b1, '{ZERO, ST_OK,    9'd2}},
      '{OP_PUSH_FRONT, 64'h8000_0000_0000_0001, 8'd0, 1'b0, '0},
      '{OP_PUSH_BACK,  64'h0123_4567_89ab_cdef, 8'd0, 1'b0, '0},
      '{OP_READ,       ZERO, 8'd3,   1'b0, '0},
      '{OP_POP_FRONT,  ONES, 8'd0,   1'b0, '0},
      '{OP_READ,       ZERO, 8'd0,   1'b0, '0},
      '{OP_POP_BACK,   ONES, 8'd0,   1'b0, '0},
      '{OP_READ,       ZERO, 8'd1,   1'b0, '0},
      '{OP_READ,       ZERO, 8'd255, 1'b0, '0},
      '{OP_POP_FRONT,  ZERO, 8'd0,   1'b0, '0},
      '{OP_POP_BACK,   ZERO, 8'd0,   1'b0, '0},
      '{OP_POP_BACK,   ZERO, 8'd0,   1'b0, '0}
   };

   double_ended_queue_store #(
      .CAPACITY(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_value(req_value),
      .req_index(req_index),
      .rsp_strobe(rsp_strobe),
      .rsp_read_value(rsp_read_value),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic deque_apply(input logic [2:0] op, input logic [WORD_W-1:0] value,
                              input logic [INDEX_W-1:0] index, output reply_type reply);
      logic [INDEX_W-1:0] slot;
      reply = '0;
      reply.status = ST_OK;
      case (op)
         OP_PUSH_BACK: begin
            if (held_count == COUNT_W'(DEPTH)) begin
               reply.status = ST_FULL;
            end else begin
               slot = ring_head + held_count[INDEX_W-1:0];
               ring_words[slot] = value;
               held_count = held_count + COUNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (held_count == '0) begin
               reply.status = ST_EMPTY;
            end else begin
               held_count = held_count - COUNT_W'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (held_count == COUNT_W'(DEPTH)) begin
               reply.status = ST_FULL;
            end else begin
               ring_head = ring_head - INDEX_W'(1);
               ring_words[ring_head] = value;
               held_count = held_count + COUNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (held_count == '0) begin
               reply.status = ST_EMPTY;
            end else begin
               ring_head = ring_head + INDEX_W'(1);
               held_count = held_count - COUNT_W'(1);
            end
         end
         OP_READ: begin
            if ({1'b0, index} >= held_count) begin
               reply.status = ST_INDEX;
            end else begin
               slot = ring_head + index;
               reply.word = ring_words[slot];
            end
         end
         default: begin
         end
      endcase
      reply.count = held_count;
   endtask

   task automatic send_request(input logic [2:0] op, input logic [WORD_W-1:0] value,
                               input logic [INDEX_W-1:0] index, input logic typed,
                               input reply_type typed_reply);
      reply_type predicted;
      req_op <= op;
      req_value <= value;
      req_index <= index;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      deque_apply(op, value, index, predicted);
      expected_ring[queued_total[3:0]] = typed ? typed_reply : predicted;
      queued_total++;
   endtask

   task automatic idle_gap();
      int unsigned gap;
      gap = bursty ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : reply_check
      reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (queued_total == checked_total) begin
            $error("unexpected response: read_value %h status %0d count %0d",
                   rsp_read_value, rsp_status, rsp_count);
            failures++;
         end else begin
            want = expected_ring[checked_total[3:0]];
            checked_total++;
            if (rsp_read_value !== want.word) begin
               $error("read_value expected %h got %h", want.word, rsp_read_value);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_count !== want.count) begin
               $error("count expected %0d got %0d", want.count, rsp_count);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin : driver
      logic [2:0]         op;
      logic [WORD_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      int unsigned        pick;
      int unsigned        push_limit;
      int unsigned        pop_limit;
      bit                 growing;
      growing = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].index,
                      directed_rows[i].typed, directed_rows[i].reply);
         idle_gap();
      end

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if ($urandom_range(0, 39) == 0) bursty = !bursty;
         if (growing && held_count == COUNT_W'(DEPTH) && $urandom_range(0, 9) == 0) begin
            growing = 1'b0;
         end
         if (!growing && held_count == '0 && $urandom_range(0, 9) == 0) growing = 1'b1;
         push_limit = growing ? 70 : 8;
         pop_limit = push_limit + (growing ? 8 : 70);
         pick = $urandom_range(0, 99);
         if (pick < push_limit) begin
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else if (pick < pop_limit) begin
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         end else if (pick < 95) begin
            op = OP_READ;
         end else begin
            op = OP_SPARE_LO + 3'($urandom_range(0, 2));
         end
         case ($urandom_range(0, 15))
            0: value = ZERO;
            1: value = ONES;
            default: value = {$urandom, $urandom};
         endcase
         if (op == OP_READ && held_count != '0 && $urandom_range(0, 9) != 0) begin
            index = INDEX_W'($urandom_range(0, held_count - 1));
         end else begin
            index = INDEX_W'($urandom_range(0, 255));
         end
         send_request(op, value, index, 1'b0, '0);
         idle_gap();
      end

      start <= 1'b0;
      while (queued_total != checked_total) @(posedge clock);
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
